// File: src/sensor_record_text_formatter_defines.svh
// assertion helpers shared by the formatter modules
`ifndef SENSOR_RECORD_TEXT_FORMATTER_DEFINES_SVH
`define SENSOR_RECORD_TEXT_FORMATTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside reset
`define SRTF_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SRTF_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define SRTF_ASSERT_RST(lbl, prop, msg)
`define SRTF_ASSERT_ANY(lbl, prop, msg)

`endif

`endif

// File: src/srtf_pkg.sv
package srtf_pkg;

   localparam int TICKS_PER_SECOND = 1000;

   // last millisecond value before the wrap, as three decimal digits
   localparam int MILLI_LAST = TICKS_PER_SECOND - 1;
   localparam logic [3:0] LAST_H = 4'(MILLI_LAST / 100);
   localparam logic [3:0] LAST_T = 4'((MILLI_LAST / 10) % 10);
   localparam logic [3:0] LAST_U = 4'(MILLI_LAST % 10);

   localparam int HEADER_LEN = 51;
   localparam logic [8*HEADER_LEN-1:0] HEADER_TEXT =
      "Time;X-acc;Y-acc;Z-acc;X-deg/s;Y-deg/s;Z-deg/s;EMG\n";
   localparam logic [5:0] HEADER_LAST = 6'(HEADER_LEN - 1);

   localparam logic [3:0] TIME_LAST   = 4'd9;
   localparam logic [2:0] LEVEL_FIELD = 3'd6;
   localparam logic [2:0] LAST_POS    = 3'd4;

   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_SEMI    = 8'h3b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;

   // datapath operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_ACCEPT = 3'd1;
   localparam logic [2:0] OP_HEADER = 3'd2;
   localparam logic [2:0] OP_TIME   = 3'd3;
   localparam logic [2:0] OP_LOAD   = 3'd4;
   localparam logic [2:0] OP_SIGN   = 3'd5;
   localparam logic [2:0] OP_DIGIT  = 3'd6;
   localparam logic [2:0] OP_SEMI   = 3'd7;

   typedef struct packed {
      logic              kind;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
      logic [11:0]        muscle_level;
   } req_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic       go;
      logic [5:0] hdr_idx;
      logic [3:0] time_idx;
      logic [2:0] field_idx;
      logic [2:0] pos;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic negative;
      logic emits;
   } status_type;

   function automatic logic [7:0] header_char(input logic [5:0] idx);
      logic [8:0] bit_pos;
      bit_pos = 9'((HEADER_LEN - 1 - int'(idx)) * 8);
      return HEADER_TEXT[bit_pos +: 8];
   endfunction

   function automatic logic [16:0] pow10(input logic [2:0] pos);
      logic [16:0] pw;
      case (pos)
         3'd0:    pw = 17'd1;
         3'd1:    pw = 17'd10;
         3'd2:    pw = 17'd100;
         3'd3:    pw = 17'd1000;
         default: pw = 17'd10000;
      endcase
      return pw;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      return CH_ZERO | {4'b0000, d};
   endfunction

endpackage

// File: src/srtf_ctrl.sv
`include "sensor_record_text_formatter_defines.svh"

module srtf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_stall,
   input  srtf_pkg::status_type status,
   output srtf_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_HEADER = 3'd1;
   localparam logic [2:0] ST_TIME   = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_SIGN   = 3'd4;
   localparam logic [2:0] ST_DIGIT  = 3'd5;
   localparam logic [2:0] ST_SEMI   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [5:0] hdr_idx_ff, hdr_idx_in;
   logic [3:0] time_idx_ff, time_idx_in;
   logic [2:0] field_idx_ff, field_idx_in;
   logic [2:0] pos_ff, pos_in;
   logic       go;

   assign req_stall = (state_ff != ST_IDLE);

   // a step that writes a character waits for room in the output register
   always_comb begin
      if (state_ff == ST_IDLE) begin
         go = req_valid;
      end else if (status.emits) begin
         go = status.out_free;
      end else begin
         go = 1'b1;
      end
   end

   always_comb begin
      cmd.go        = go;
      cmd.hdr_idx   = hdr_idx_ff;
      cmd.time_idx  = time_idx_ff;
      cmd.field_idx = field_idx_ff;
      cmd.pos       = pos_ff;
      case (state_ff)
         ST_IDLE:   cmd.op = req_valid ? srtf_pkg::OP_ACCEPT : srtf_pkg::OP_NONE;
         ST_HEADER: cmd.op = srtf_pkg::OP_HEADER;
         ST_TIME:   cmd.op = srtf_pkg::OP_TIME;
         ST_LOAD:   cmd.op = srtf_pkg::OP_LOAD;
         ST_SIGN:   cmd.op = srtf_pkg::OP_SIGN;
         ST_DIGIT:  cmd.op = srtf_pkg::OP_DIGIT;
         ST_SEMI:   cmd.op = srtf_pkg::OP_SEMI;
         default:   cmd.op = srtf_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      hdr_idx_in   = hdr_idx_ff;
      time_idx_in  = time_idx_ff;
      field_idx_in = field_idx_ff;
      pos_in       = pos_ff;
      if (go) begin
         case (state_ff)
            ST_IDLE: begin
               hdr_idx_in   = '0;
               time_idx_in  = '0;
               field_idx_in = '0;
               state_in     = (req_kind == srtf_pkg::KIND_RESTART) ? ST_HEADER : ST_TIME;
            end
            ST_HEADER: begin
               if (hdr_idx_ff == srtf_pkg::HEADER_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  hdr_idx_in = hdr_idx_ff + 6'd1;
               end
            end
            ST_TIME: begin
               if (time_idx_ff == srtf_pkg::TIME_LAST) begin
                  state_in = ST_LOAD;
               end else begin
                  time_idx_in = time_idx_ff + 4'd1;
               end
            end
            ST_LOAD: begin
               pos_in   = srtf_pkg::LAST_POS;
               state_in = status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
               state_in = ST_DIGIT;
            end
            ST_DIGIT: begin
               if (pos_ff == '0) begin
                  state_in = ST_SEMI;
               end else begin
                  pos_in = pos_ff - 3'd1;
               end
            end
            ST_SEMI: begin
               if (field_idx_ff == srtf_pkg::LEVEL_FIELD) begin
                  state_in = ST_IDLE;
               end else begin
                  field_idx_in = field_idx_ff + 3'd1;
                  state_in     = ST_LOAD;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hdr_idx_ff   <= '0;
         time_idx_ff  <= '0;
         field_idx_ff <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         hdr_idx_ff   <= hdr_idx_in;
         time_idx_ff  <= time_idx_in;
         field_idx_ff <= field_idx_in;
         pos_ff       <= pos_in;
      end
   end

   `SRTF_ASSERT_RST(a_restart_starts_header, (state_ff == ST_IDLE && req_valid && req_kind == srtf_pkg::KIND_RESTART) |=> (state_ff == ST_HEADER && hdr_idx_ff == '0), "restart did not open the header line")
   `SRTF_ASSERT_RST(a_hold_without_go, (state_ff != ST_IDLE && !go) |=> $stable({state_ff, hdr_idx_ff, time_idx_ff, field_idx_ff, pos_ff}), "sequencer moved while waiting")
   `SRTF_ASSERT_RST(a_last_field_ends_line, (state_ff == ST_SEMI && go && field_idx_ff == srtf_pkg::LEVEL_FIELD) |=> state_ff == ST_IDLE, "line did not end after the level value")
   `SRTF_ASSERT_RST(a_field_in_range, state_ff != ST_IDLE |-> field_idx_ff <= srtf_pkg::LEVEL_FIELD, "field index out of range")

endmodule

// File: src/srtf_dp.sv
`include "sensor_record_text_formatter_defines.svh"

module srtf_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  srtf_pkg::req_type    req_item,
   input  srtf_pkg::cmd_type    cmd,
   output srtf_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output srtf_pkg::rsp_type    rsp_item
);

   logic [15:0] sample_ff [0:5];
   logic [11:0] level_ff;

   // running time kept as decimal digits
   logic [3:0] milli_h_ff, milli_h_in;
   logic [3:0] milli_t_ff, milli_t_in;
   logic [3:0] milli_u_ff, milli_u_in;
   logic [2:0] sec_t_ff, sec_t_in;
   logic [3:0] sec_u_ff, sec_u_in;
   logic [3:0] min_t_ff, min_t_in;
   logic [3:0] min_u_ff, min_u_in;

   logic [15:0] mag_ff, mag_in;
   logic        started_ff, started_in;
   logic        rsp_valid_ff;
   srtf_pkg::rsp_type rsp_item_ff;

   logic [15:0] sel_value;
   logic        sel_neg;
   logic [15:0] sel_mag;
   logic [16:0] pw;
   logic [16:0] thr;
   logic [16:0] sub;
   logic [3:0]  digit;
   logic        digit_emit;
   logic        out_free;
   logic        emits;
   logic        load;
   srtf_pkg::rsp_type char_out;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = cmd.go && (cmd.op == srtf_pkg::OP_ACCEPT);

   always_comb begin
      case (cmd.field_idx)
         3'd0:    sel_value = sample_ff[0];
         3'd1:    sel_value = sample_ff[1];
         3'd2:    sel_value = sample_ff[2];
         3'd3:    sel_value = sample_ff[3];
         3'd4:    sel_value = sample_ff[4];
         3'd5:    sel_value = sample_ff[5];
         default: sel_value = {4'b0000, level_ff};
      endcase
   end

   assign sel_neg = (cmd.field_idx != srtf_pkg::LEVEL_FIELD) && sel_value[15];
   // two's complement magnitude; 8000 hex stays 32768
   assign sel_mag = sel_neg ? 16'(16'd0 - sel_value) : sel_value;

   // one decimal digit per step: largest multiple of the place value that fits
   always_comb begin
      pw    = srtf_pkg::pow10(cmd.pos);
      digit = '0;
      sub   = '0;
      thr   = '0;
      for (int k = 1; k <= 9; k++) begin
         thr = 17'(pw * 17'(k));
         if ({1'b0, mag_ff} >= thr) begin
            digit = 4'(k);
            sub   = thr;
         end
      end
   end

   assign digit_emit = (digit != '0) || started_ff || (cmd.pos == '0);

   always_comb begin
      case (cmd.op)
         srtf_pkg::OP_HEADER, srtf_pkg::OP_TIME,
         srtf_pkg::OP_SIGN, srtf_pkg::OP_SEMI: emits = 1'b1;
         srtf_pkg::OP_DIGIT:                  emits = digit_emit;
         default:                             emits = 1'b0;
      endcase
   end

   assign status.out_free = out_free;
   assign status.negative = sel_neg;
   assign status.emits    = emits;

   always_comb begin
      char_out.line_end = 1'b0;
      case (cmd.op)
         srtf_pkg::OP_HEADER: begin
            char_out.text_byte = srtf_pkg::header_char(cmd.hdr_idx);
            char_out.line_end  = (cmd.hdr_idx == srtf_pkg::HEADER_LAST);
         end
         srtf_pkg::OP_TIME: begin
            case (cmd.time_idx)
               4'd0:    char_out.text_byte = srtf_pkg::digit_char(min_t_ff);
               4'd1:    char_out.text_byte = srtf_pkg::digit_char(min_u_ff);
               4'd3:    char_out.text_byte = srtf_pkg::digit_char({1'b0, sec_t_ff});
               4'd4:    char_out.text_byte = srtf_pkg::digit_char(sec_u_ff);
               4'd6:    char_out.text_byte = srtf_pkg::digit_char(milli_h_ff);
               4'd7:    char_out.text_byte = srtf_pkg::digit_char(milli_t_ff);
               4'd8:    char_out.text_byte = srtf_pkg::digit_char(milli_u_ff);
               4'd9:    char_out.text_byte = srtf_pkg::CH_SEMI;
               default: char_out.text_byte = srtf_pkg::CH_DOT;
            endcase
         end
         srtf_pkg::OP_SIGN: begin
            char_out.text_byte = srtf_pkg::CH_MINUS;
         end
         srtf_pkg::OP_DIGIT: begin
            char_out.text_byte = srtf_pkg::digit_char(digit);
         end
         srtf_pkg::OP_SEMI: begin
            if (cmd.field_idx == srtf_pkg::LEVEL_FIELD) begin
               char_out.text_byte = srtf_pkg::CH_NEWLINE;
               char_out.line_end  = 1'b1;
            end else begin
               char_out.text_byte = srtf_pkg::CH_SEMI;
            end
         end
         default: begin
            char_out.text_byte = srtf_pkg::CH_SEMI;
         end
      endcase
   end

   // clock advance on a tick, clear on restart
   always_comb begin
      milli_h_in = milli_h_ff;
      milli_t_in = milli_t_ff;
      milli_u_in = milli_u_ff;
      sec_t_in   = sec_t_ff;
      sec_u_in   = sec_u_ff;
      min_t_in   = min_t_ff;
      min_u_in   = min_u_ff;
      if (load) begin
         if (req_item.kind == srtf_pkg::KIND_RESTART) begin
            milli_h_in = '0;
            milli_t_in = '0;
            milli_u_in = '0;
            sec_t_in   = '0;
            sec_u_in   = '0;
            min_t_in   = '0;
            min_u_in   = '0;
         end else if (milli_h_ff == srtf_pkg::LAST_H && milli_t_ff == srtf_pkg::LAST_T &&
                      milli_u_ff == srtf_pkg::LAST_U) begin
            milli_h_in = '0;
            milli_t_in = '0;
            milli_u_in = '0;
            if (sec_t_ff == 3'd5 && sec_u_ff == 4'd9) begin
               sec_t_in = '0;
               sec_u_in = '0;
               if (min_t_ff == 4'd9 && min_u_ff == 4'd9) begin
                  min_t_in = '0;
                  min_u_in = '0;
               end else if (min_u_ff == 4'd9) begin
                  min_u_in = '0;
                  min_t_in = min_t_ff + 4'd1;
               end else begin
                  min_u_in = min_u_ff + 4'd1;
               end
            end else if (sec_u_ff == 4'd9) begin
               sec_u_in = '0;
               sec_t_in = sec_t_ff + 3'd1;
            end else begin
               sec_u_in = sec_u_ff + 4'd1;
            end
         end else if (milli_u_ff == 4'd9) begin
            milli_u_in = '0;
            if (milli_t_ff == 4'd9) begin
               milli_t_in = '0;
               milli_h_in = milli_h_ff + 4'd1;
            end else begin
               milli_t_in = milli_t_ff + 4'd1;
            end
         end else begin
            milli_u_in = milli_u_ff + 4'd1;
         end
      end
   end

   always_comb begin
      mag_in     = mag_ff;
      started_in = started_ff;
      if (cmd.go && cmd.op == srtf_pkg::OP_LOAD) begin
         mag_in     = sel_mag;
         started_in = 1'b0;
      end else if (cmd.go && cmd.op == srtf_pkg::OP_DIGIT) begin
         mag_in     = 16'({1'b0, mag_ff} - sub);
         started_in = started_ff || digit_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff[0] <= req_item.accel_x;
         sample_ff[1] <= req_item.accel_y;
         sample_ff[2] <= req_item.accel_z;
         sample_ff[3] <= req_item.rate_x;
         sample_ff[4] <= req_item.rate_y;
         sample_ff[5] <= req_item.rate_z;
         level_ff     <= req_item.muscle_level;
      end
      mag_ff     <= mag_in;
      started_ff <= started_in;
      if (cmd.go && emits) begin
         rsp_item_ff <= char_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         milli_h_ff   <= '0;
         milli_t_ff   <= '0;
         milli_u_ff   <= '0;
         sec_t_ff     <= '0;
         sec_u_ff     <= '0;
         min_t_ff     <= '0;
         min_u_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         milli_h_ff <= milli_h_in;
         milli_t_ff <= milli_t_in;
         milli_u_ff <= milli_u_in;
         sec_t_ff   <= sec_t_in;
         sec_u_ff   <= sec_u_in;
         min_t_ff   <= min_t_in;
         min_u_ff   <= min_u_in;
         if (cmd.go && emits) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `SRTF_ASSERT_RST(a_digits_exhaust_value, (cmd.op == srtf_pkg::OP_DIGIT && cmd.go && cmd.pos == '0) |=> mag_ff == '0, "value not fully converted after units digit")
   `SRTF_ASSERT_RST(a_time_is_decimal, milli_h_ff <= 4'd9 && milli_t_ff <= 4'd9 && milli_u_ff <= 4'd9 && sec_t_ff <= 3'd5 && sec_u_ff <= 4'd9 && min_t_ff <= 4'd9 && min_u_ff <= 4'd9, "time digit out of range")
   `SRTF_ASSERT_ANY(a_reset_empties_output, reset |=> !rsp_valid_ff, "output register not emptied by reset")

endmodule

// File: src/sensor_record_text_formatter.sv
// channel   ports                              moves
// request   req_valid, req_stall, req_item     one tick or restart item
// response  rsp_valid, rsp_stall, rsp_item     one text byte per item
//
// a restart is accepted, then the 51 header bytes follow
// a tick is accepted, then 10 time bytes follow, then per value one
// load step, an optional minus, five decimal place steps and the separator
// the five place steps per value come from LAST_POS and share one digit unit
// reset is synchronous and clears the clock to 00.00.000 and the sequencer
// a stalled response holds the sequencer; the next request is taken once
// the last byte sits in the output register
`include "sensor_record_text_formatter_defines.svh"

module sensor_record_text_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  srtf_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srtf_pkg::rsp_type rsp_item
);

   srtf_pkg::cmd_type    cmd;
   srtf_pkg::status_type status;

   srtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srtf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
